>>> src/bf_tape_machine_core_defines.svh
// Assertion macros used by the tape machine core RTL.
`ifndef BF_TAPE_MACHINE_CORE_DEFINES_SVH
`define BF_TAPE_MACHINE_CORE_DEFINES_SVH

// check that a condition holds at every clock edge out of reset
`define BFTM_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// check that a condition implies another in the same cycle
`define BFTM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that a condition implies another in the next cycle
`define BFTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bftm_pkg.sv
// Package with sizes, command codes, status codes and types of the tape machine core.
package bftm_pkg;

	localparam int CODE_DEPTH = 4096;
	localparam int NEST_DEPTH = 256;
	localparam int TAPE_DEPTH = 32768;

	localparam int CODE_AW = $clog2(CODE_DEPTH);
	localparam int NEST_AW = $clog2(NEST_DEPTH);
	localparam int TAPE_AW = $clog2(TAPE_DEPTH);
	localparam int LEN_W   = CODE_AW + 1;
	localparam int TOP_W   = NEST_AW + 1;
	localparam int TLEN_W  = TAPE_AW + 1;
	localparam int CFG_W   = 16;

	localparam logic [CFG_W-1:0] TAPE_RESET = 16'd30000;

	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_OPEN  = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_MATCH,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic step_fwd;
		logic step_back;
	} ptr_ctl_t;

endpackage

>>> src/bftm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module bftm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/bftm_ptr.sv
// Data pointer step logic: tape length clamp and wrap on move right or left.
module bftm_ptr import bftm_pkg::*; (
	input  logic [TAPE_AW-1:0] dp,
	input  logic [CFG_W-1:0]   tape_cells,
	input  ptr_ctl_t           ctl,
	output logic [TAPE_AW-1:0] dp_next
);

	logic [CFG_W:0]    cells_ext;
	logic [TLEN_W-1:0] tlen;
	logic [TLEN_W-1:0] tlen_m1;
	logic [TLEN_W-1:0] dp_inc;

	always_comb begin
		cells_ext = {1'b0, tape_cells};
		if (cells_ext == '0) begin
			tlen = TLEN_W'(1);
		end else if (cells_ext > (CFG_W + 1)'(TAPE_DEPTH)) begin
			tlen = TLEN_W'(TAPE_DEPTH);
		end else begin
			tlen = TLEN_W'(cells_ext);
		end
		tlen_m1 = tlen - TLEN_W'(1);
		dp_inc  = {1'b0, dp} + TLEN_W'(1);
		if (ctl.step_fwd) begin
			dp_next = (dp_inc >= tlen) ? '0 : dp_inc[TAPE_AW-1:0];
		end else if (ctl.step_back) begin
			dp_next = (dp == '0) ? tlen_m1[TAPE_AW-1:0] : dp - TAPE_AW'(1);
		end else begin
			dp_next = dp;
		end
	end

endmodule

>>> src/bf_tape_machine_core.sv
// Top level of the tape machine core: sequencer, load and execute datapath, memories.
//
// Each input beat is either a program character to load (mode 0) or one instruction to
// execute (mode 1), and each gives exactly one result beat. A beat is taken only while the
// core is idle; an execute beat and most load beats do a synchronous read of the program,
// match table, open-bracket stack and tape memories, then update and write-back, and a ']'
// that closes a bracket also passes through S_MATCH because both match table entries are
// written through the one write port. The result sits in an output register, so the next
// beat is taken while it waits; the core only holds an item at its update cycle while a
// previous result is still stalled. After reset the tape is zeroed in a sweep over all 32768
// cells, one cell a cycle, during which no beat is taken; tape_cells may be written at any time.
`include "bf_tape_machine_core_defines.svh"

module bf_tape_machine_core import bftm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             mode,
	input  logic [7:0]       code_char,
	input  logic             is_last,
	input  logic [7:0]       input_byte,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             input_used,
	output logic             halted,
	output logic [1:0]       status
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]   tape_cells_q;
	logic [TAPE_AW-1:0] clr_cnt_q;
	logic [TAPE_AW-1:0] dp_q;
	logic [LEN_W-1:0]   pc_q;
	logic [LEN_W-1:0]   len_q;
	logic [TOP_W-1:0]   top_q;
	logic [1:0]         err_q;
	logic               load_closed_q;
	logic [CODE_AW-1:0] match_op_q;
	logic [CODE_AW-1:0] match_pos_q;

	logic [7:0] ch_s1;
	logic       last_s1;
	logic [7:0] inb_s1;

	logic       res_valid_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       input_used_q;
	logic       halted_q;
	logic [1:0] status_q;

	logic item_accept;
	logic slot_free;
	logic go;
	logic produce;
	logic clr_done;

	logic [CODE_AW-1:0] match_rdata;
	logic [7:0]         prog_rdata8;
	logic [CODE_AW-1:0] stack_rdata;
	logic [7:0]         tape_rdata;

	logic               prog_we;
	logic               match_we;
	logic [CODE_AW-1:0] match_waddr;
	logic [CODE_AW-1:0] match_wdata;
	logic               stack_we;
	logic [NEST_AW-1:0] stack_waddr;
	logic [TOP_W-1:0]   top_less;
	logic               tape_we;
	logic [TAPE_AW-1:0] tape_waddr;
	logic [7:0]         tape_wdata;
	logic               exec_re;
	logic               load_re;

	logic [1:0]         ld_err;
	logic [TOP_W-1:0]   ld_top_base;
	logic [TOP_W-1:0]   ld_top;
	logic [LEN_W-1:0]   ld_len;
	logic [LEN_W-1:0]   ld_pc;
	logic [CODE_AW-1:0] ld_pos;
	logic               ld_push;
	logic               ld_pop;
	logic               ld_store;
	logic               ld_closed;

	logic               ex_run;
	logic [LEN_W-1:0]   ex_pc_nxt;
	logic               ex_tape_we;
	logic [7:0]         ex_tape_wdata;
	logic               ex_out_valid;
	logic               ex_used;
	ptr_ctl_t           ex_ptr_ctl;
	logic [TAPE_AW-1:0] ex_dp_nxt;

	assign item_accept = item_valid && !item_stall;
	assign slot_free   = !res_valid_q || !res_stall;
	assign clr_done    = (clr_cnt_q == TAPE_AW'(TAPE_DEPTH - 1));
	assign top_less    = top_q - TOP_W'(1);

	bftm_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (ld_pos),
		.wdata (ch_s1),
		.re    (exec_re),
		.raddr (pc_q[CODE_AW-1:0]),
		.rdata (prog_rdata8)
	);

	bftm_ram #(.WIDTH(CODE_AW), .DEPTH(CODE_DEPTH)) u_match_ram (
		.clk   (clk),
		.we    (match_we),
		.waddr (match_waddr),
		.wdata (match_wdata),
		.re    (exec_re),
		.raddr (pc_q[CODE_AW-1:0]),
		.rdata (match_rdata)
	);

	bftm_ram #(.WIDTH(CODE_AW), .DEPTH(NEST_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (ld_pos),
		.re    (load_re),
		.raddr (top_less[NEST_AW-1:0]),
		.rdata (stack_rdata)
	);

	bftm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (exec_re),
		.raddr (dp_q),
		.rdata (tape_rdata)
	);

	bftm_ptr u_ptr (
		.dp         (dp_q),
		.tape_cells (tape_cells_q),
		.ctl        (ex_ptr_ctl),
		.dp_next    (ex_dp_nxt)
	);

	always_comb begin : load_calc
		ld_top_base = load_closed_q ? '0 : top_q;
		ld_err      = load_closed_q ? ST_OK : err_q;
		ld_top      = ld_top_base;
		ld_len      = load_closed_q ? '0 : len_q;
		ld_pc       = load_closed_q ? '0 : pc_q;
		ld_pos      = ld_len[CODE_AW-1:0];
		ld_push     = 1'b0;
		ld_pop      = 1'b0;
		ld_store    = 1'b0;
		ld_closed   = 1'b0;
		if (ld_err == ST_OK) begin
			if (ld_len >= LEN_W'(CODE_DEPTH)) begin
				ld_err = ST_OVF;
			end else begin
				if (ch_s1 == CH_OPEN) begin
					if (ld_top >= TOP_W'(NEST_DEPTH)) begin
						ld_err = ST_OVF;
					end else begin
						ld_push = 1'b1;
						ld_top  = ld_top + TOP_W'(1);
					end
				end else if (ch_s1 == CH_CLOSE) begin
					if (ld_top == '0) begin
						ld_err = ST_CLOSE;
					end else begin
						ld_pop = 1'b1;
						ld_top = ld_top - TOP_W'(1);
					end
				end
				if (ld_err == ST_OK) begin
					ld_store = 1'b1;
					ld_len   = ld_len + LEN_W'(1);
				end
			end
		end
		if (last_s1) begin
			if (ld_err == ST_OK && ld_top != '0) begin
				ld_err = ST_OPEN;
			end
			ld_closed = 1'b1;
		end
	end

	always_comb begin : exec_calc
		ex_run        = load_closed_q && (err_q == ST_OK) && (pc_q < len_q) &&
		                (pc_q < LEN_W'(CODE_DEPTH));
		ex_pc_nxt     = pc_q + LEN_W'(1);
		ex_tape_we    = 1'b0;
		ex_tape_wdata = tape_rdata;
		ex_out_valid  = 1'b0;
		ex_used       = 1'b0;
		ex_ptr_ctl    = '0;
		case (prog_rdata8)
			CH_RIGHT: ex_ptr_ctl.step_fwd = 1'b1;
			CH_LEFT:  ex_ptr_ctl.step_back = 1'b1;
			CH_PLUS: begin
				ex_tape_we    = 1'b1;
				ex_tape_wdata = tape_rdata + 8'd1;
			end
			CH_MINUS: begin
				ex_tape_we    = 1'b1;
				ex_tape_wdata = tape_rdata - 8'd1;
			end
			CH_DOT:   ex_out_valid = 1'b1;
			CH_COMMA: begin
				ex_tape_we    = 1'b1;
				ex_tape_wdata = inb_s1;
				ex_used       = 1'b1;
			end
			CH_OPEN: begin
				if (tape_rdata == 8'd0) begin
					ex_pc_nxt = {1'b0, match_rdata} + LEN_W'(1);
				end
			end
			CH_CLOSE: begin
				if (tape_rdata != 8'd0) begin
					ex_pc_nxt = {1'b0, match_rdata} + LEN_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin : next_state
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_accept) state_d = mode ? S_EXEC : S_LOAD;
			end
			S_LOAD: begin
				if (slot_free) state_d = ld_pop ? S_MATCH : S_IDLE;
			end
			S_MATCH: state_d = S_IDLE;
			S_EXEC: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin : fsm_outputs
		item_stall  = 1'b1;
		go          = 1'b0;
		exec_re     = 1'b0;
		load_re     = 1'b0;
		prog_we     = 1'b0;
		match_we    = 1'b0;
		match_waddr = ld_pos;
		match_wdata = stack_rdata;
		stack_we    = 1'b0;
		stack_waddr = ld_top_base[NEST_AW-1:0];
		tape_we     = 1'b0;
		tape_waddr  = dp_q;
		tape_wdata  = ex_tape_wdata;
		case (state_q)
			S_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_cnt_q;
				tape_wdata = 8'd0;
			end
			S_IDLE: begin
				item_stall = 1'b0;
				exec_re    = item_valid && mode;
				load_re    = item_valid && !mode;
			end
			S_LOAD: begin
				go       = slot_free;
				prog_we  = slot_free && ld_store;
				match_we = slot_free && ld_pop;
				stack_we = slot_free && ld_push;
			end
			S_MATCH: begin
				match_we    = 1'b1;
				match_waddr = match_op_q;
				match_wdata = match_pos_q;
			end
			S_EXEC: begin
				go      = slot_free;
				tape_we = slot_free && ex_run && ex_tape_we;
			end
			default: ;
		endcase
	end

	assign produce = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			tape_cells_q  <= TAPE_RESET;
			clr_cnt_q     <= '0;
			dp_q          <= '0;
			pc_q          <= '0;
			len_q         <= '0;
			top_q         <= '0;
			err_q         <= ST_OK;
			load_closed_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				tape_cells_q <= cfg_wr_data;
			end
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + TAPE_AW'(1);
			end
			if (state_q == S_LOAD && go) begin
				err_q         <= ld_err;
				top_q         <= ld_top;
				len_q         <= ld_len;
				pc_q          <= ld_pc;
				load_closed_q <= ld_closed;
			end
			if (state_q == S_EXEC && go && ex_run) begin
				pc_q <= ex_pc_nxt;
				dp_q <= ex_dp_nxt;
			end
			if (produce) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			ch_s1   <= code_char;
			last_s1 <= is_last;
			inb_s1  <= input_byte;
		end
		if (state_q == S_LOAD && go) begin
			match_op_q  <= stack_rdata;
			match_pos_q <= ld_pos;
		end
		if (produce) begin
			if (state_q == S_EXEC) begin
				out_valid_q  <= ex_run && ex_out_valid;
				out_byte_q   <= (ex_run && ex_out_valid) ? tape_rdata : 8'd0;
				input_used_q <= ex_run && ex_used;
				halted_q     <= ex_run ? (ex_pc_nxt >= len_q) : (pc_q >= len_q);
				status_q     <= err_q;
			end else begin
				out_valid_q  <= 1'b0;
				out_byte_q   <= 8'd0;
				input_used_q <= 1'b0;
				halted_q     <= (ld_pc >= ld_len);
				status_q     <= ld_err;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign input_used = input_used_q;
	assign halted     = halted_q;
	assign status     = status_q;

	`BFTM_ASSERT_IMPLY(a_no_result_in_clear, state_q == S_CLEAR, !res_valid_q,
		"result during tape clear")
	`BFTM_ASSERT_NEXT(a_exec_follows_accept, item_accept && mode, state_q == S_EXEC,
		"execute beat not started")
	`BFTM_ASSERT_IMPLY(a_match_after_load, state_q == S_MATCH, $past(state_q) == S_LOAD,
		"match write out of order")
	`BFTM_ASSERT_ALWAYS(a_stack_bound, top_q <= TOP_W'(NEST_DEPTH), "stack top beyond depth")
	`BFTM_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(CODE_DEPTH), "program length beyond depth")

endmodule
